// File: design/fmss_pkg.sv
// fmss_pkg: shared constants, types and register indexes of the substring search.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmss_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int COUNT_BITS  = 32;
	localparam int INDEX_W     = 32;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_LEN_W   = 5;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = CFG_IDX_W'(2);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [7:0]            END_BYTE  = 8'h00;

	typedef logic [MAX_PATTERN-1:0][7:0] byte_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       take;
		logic       close;
	} text_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic pop;
		logic pop_close;
	} back_status_t;

endpackage

`default_nettype wire

// File: design/first_match_substring_search.sv
// first_match_substring_search: streaming first-occurrence pattern search, top level.
// Result path: an accepted closing transfer passes through the queue and then the result register.
// Throughput: one text transfer per cycle while the queue is not full; set by the combinational window compare.
// Stalls: a close waits while the previous result is held; four queued transfers stop text_ready.
// Reset: arst_n clears config registers, search state, queue and result valid.
// Depends on fmss_pkg, fmss_front, fmss_queue, fmss_back.
`timescale 1ns / 1ps
`default_nettype none

module first_match_substring_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fmss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fmss_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              text_valid,
	output logic                              text_ready,
	input  logic [7:0]                        text_byte,
	input  logic                              byte_present,
	input  logic                              end_of_text,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              found,
	output logic [fmss_pkg::INDEX_W-1:0]      match_index,
	output logic                              count_overflow
);
	import fmss_pkg::*;

	logic [CFG_W-1:0]     pat_low_q;
	logic [CFG_W-1:0]     pat_high_q;
	logic [CFG_LEN_W-1:0] pat_len_q;
	logic [2*CFG_W-1:0]   pat_all;
	byte_row_t            pattern;
	logic [LEN_W-1:0]     act_len;

	queue_status_t q_status;
	back_status_t  b_status;
	text_op_t      push_op;
	text_op_t      head_op;
	logic          push;
	logic          head_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  pat_len_q  <= cfg_data[CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_all = {pat_high_q, pat_low_q};
	assign pattern = pat_all[MAX_PATTERN*8-1:0];
	assign act_len = (pat_len_q > CFG_LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
		: LEN_W'(pat_len_q);

	fmss_front u_front (
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.byte_present (byte_present),
		.end_of_text  (end_of_text),
		.q_status     (q_status),
		.push         (push),
		.push_op      (push_op)
	);

	fmss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (b_status.pop),
		.head_valid (head_valid),
		.head_op    (head_op),
		.status     (q_status)
	);

	fmss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_op        (head_op),
		.pattern        (pattern),
		.act_len        (act_len),
		.status         (b_status),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.found          (found),
		.match_index    (match_index),
		.count_overflow (count_overflow)
	);

	a_queue_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty together");

	a_close_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		b_status.pop_close |=> result_valid)
		else $error("close consumed without a result");

	a_len_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		act_len <= LEN_W'(MAX_PATTERN))
		else $error("active pattern length out of range");

	a_index_zero_when_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (match_index == '0))
		else $error("index nonzero without a match");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		b_status.pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: design/fmss_front.sv
// fmss_front: takes text transfers, classifies them into byte and close operations.
// Depends on fmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmss_front (
	input  logic                   text_valid,
	output logic                   text_ready,
	input  logic [7:0]             text_byte,
	input  logic                   byte_present,
	input  logic                   end_of_text,
	input  fmss_pkg::queue_status_t q_status,
	output logic                   push,
	output fmss_pkg::text_op_t     push_op
);
	import fmss_pkg::*;

	logic is_end_byte;

	assign is_end_byte   = byte_present && (text_byte == END_BYTE);
	assign push_op.data  = text_byte;
	assign push_op.take  = byte_present && !is_end_byte;
	assign push_op.close = end_of_text || is_end_byte;

	assign text_ready = !q_status.full;
	// items with neither a byte nor a close do nothing and are dropped here
	assign push = text_valid && !q_status.full && (push_op.take || push_op.close);

endmodule

`default_nettype wire

// File: design/fmss_queue.sv
// fmss_queue: small FIFO of classified operations between front and back.
// Depends on fmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmss_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  fmss_pkg::text_op_t      push_op,
	input  logic                    pop,
	output logic                    head_valid,
	output fmss_pkg::text_op_t      head_op,
	output fmss_pkg::queue_status_t status
);
	import fmss_pkg::*;

	text_op_t          store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   fill_q;

	assign status.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);
	assign head_valid   = !status.empty;
	assign head_op      = store_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/fmss_back.sv
// fmss_back: window, byte counter, first-match tracking and the result register.
// Depends on fmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmss_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  fmss_pkg::text_op_t         head_op,
	input  fmss_pkg::byte_row_t        pattern,
	input  logic [fmss_pkg::LEN_W-1:0] act_len,
	output fmss_pkg::back_status_t     status,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       found,
	output logic [fmss_pkg::INDEX_W-1:0] match_index,
	output logic                       count_overflow
);
	import fmss_pkg::*;

	byte_row_t             win_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  match_q;
	logic [COUNT_BITS-1:0] first_q;
	logic                  ovf_q;

	logic                  res_valid_q;
	logic                  found_q;
	logic [INDEX_W-1:0]    index_q;
	logic                  res_ovf_q;

	byte_row_t             win_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  match_n;
	logic [COUNT_BITS-1:0] first_n;
	logic                  ovf_n;
	logic                  sat_hit;
	logic                  new_match;
	logic [MAX_PATTERN-1:0] eq;
	logic                  pop;
	logic                  take;

	assign pop  = head_valid && (!head_op.close || !res_valid_q || result_ready);
	assign take = head_op.take;

	always_comb begin
		win_n = win_q;
		if (take) begin
			for (int j = MAX_PATTERN - 1; j > 0; j--) begin
				win_n[j] = win_q[j-1];
			end
			win_n[0] = head_op.data;
		end
	end

	// pattern byte k lines up with window entry len-1-k
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (LEN_W'(k) < act_len) begin
				eq[k] = (pattern[k] ==
					win_n[WIN_IDX_W'(act_len - LEN_W'(1) - LEN_W'(k))]);
			end else begin
				eq[k] = 1'b1;
			end
		end
	end

	assign sat_hit   = take && (cnt_q == COUNT_MAX);
	assign cnt_n     = (take && !sat_hit) ? cnt_q + COUNT_BITS'(1) : cnt_q;
	assign ovf_n     = ovf_q || sat_hit;
	assign new_match = take && !sat_hit && !match_q && !ovf_q && (act_len != '0)
		&& (cnt_n >= COUNT_BITS'(act_len)) && (&eq);
	assign match_n   = match_q || new_match;
	assign first_n   = new_match ? cnt_n - COUNT_BITS'(act_len) : first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			cnt_q   <= '0;
			match_q <= 1'b0;
			first_q <= '0;
			ovf_q   <= 1'b0;
		end else if (pop) begin
			if (head_op.close) begin
				win_q   <= '0;
				cnt_q   <= '0;
				match_q <= 1'b0;
				first_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				win_q   <= win_n;
				cnt_q   <= cnt_n;
				match_q <= match_n;
				first_q <= first_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && head_op.close) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_op.close) begin
			found_q   <= (act_len == '0) || match_n;
			index_q   <= ((act_len != '0) && match_n) ? INDEX_W'(first_n) : '0;
			res_ovf_q <= ovf_n;
		end
	end

	assign status.pop       = pop;
	assign status.pop_close = pop && head_op.close;
	assign result_valid     = res_valid_q;
	assign found            = found_q;
	assign match_index      = index_q;
	assign count_overflow   = res_ovf_q;

endmodule

`default_nettype wire

// File: bench/fmss_checker.sv
// fmss_checker: watches the configuration, text and result channels of the substring search,
// predicts each search report and compares it field by field with what the block returns.
// Depends on fmss_pkg.
`timescale 1ns / 1ps

module fmss_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fmss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fmss_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           text_valid,
	input  logic                           text_ready,
	input  logic [7:0]                     text_byte,
	input  logic                           byte_present,
	input  logic                           end_of_text,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic                           found,
	input  logic [fmss_pkg::INDEX_W-1:0]   match_index,
	input  logic                           count_overflow,
	output int                             errors,
	output int                             waiting,
	output int                             reports_checked,
	output int                             reports_found
);
	import fmss_pkg::*;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] index;
		logic               overflow;
	} search_report_t;

	logic [CFG_W-1:0]      pat_low;
	logic [CFG_W-1:0]      pat_high;
	logic [CFG_LEN_W-1:0]  pat_len;
	logic [7:0]            window [MAX_PATTERN];
	logic [COUNT_BITS-1:0] byte_count;
	logic [COUNT_BITS-1:0] first_pos;
	logic                  hit;
	logic                  count_full;
	search_report_t        due_reports [$];
	int                    n_err;
	int                    n_checked;
	int                    n_found;

	function automatic int len_in_use();
		return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
	endfunction

	function automatic logic [7:0] pattern_char(input int k);
		return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
	endfunction

	task automatic clear_search();
		int i;
		for (i = 0; i < MAX_PATTERN; i++)
			window[i] = 8'h00;
		byte_count = '0;
		first_pos  = '0;
		hit        = 1'b0;
		count_full = 1'b0;
	endtask

	task automatic take_text_byte(input logic [7:0] b);
		int   n;
		int   i;
		logic same;
		n = len_in_use();
		for (i = MAX_PATTERN - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = b;
		if (byte_count == COUNT_MAX) begin
			count_full = 1'b1;
			return;
		end
		byte_count = byte_count + 1'b1;
		if (hit || count_full || n == 0 || byte_count < n)
			return;
		same = 1'b1;
		for (i = 0; i < n; i++)
			if (pattern_char(i) != window[n-1-i])
				same = 1'b0;
		if (same) begin
			hit       = 1'b1;
			first_pos = byte_count - COUNT_BITS'(n);
		end
	endtask

	task automatic close_text();
		search_report_t r;
		r.overflow = count_full;
		if (len_in_use() == 0) begin
			r.found = 1'b1;
			r.index = '0;
		end else begin
			r.found = hit;
			r.index = hit ? first_pos[INDEX_W-1:0] : '0;
		end
		due_reports.push_back(r);
		clear_search();
	endtask

	task automatic check_field(input string name, input logic [INDEX_W-1:0] want,
			input logic [INDEX_W-1:0] got);
		if (want !== got) begin
			n_err++;
			$display("%t %s: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		search_report_t want;
		logic           closing;
		if (!arst_n) begin
			pat_low  = '0;
			pat_high = '0;
			pat_len  = '0;
			clear_search();
			due_reports.delete();
			n_err     = 0;
			n_checked = 0;
			n_found   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PAT_LOW:  pat_low  = cfg_data;
					REG_PAT_HIGH: pat_high = cfg_data;
					REG_PAT_LEN:  pat_len  = cfg_data[CFG_LEN_W-1:0];
					default: ;
				endcase
			end
			if (text_valid && text_ready) begin
				closing = end_of_text;
				if (byte_present) begin
					if (text_byte == END_BYTE)
						closing = 1'b1;
					else
						take_text_byte(text_byte);
				end
				if (closing)
					close_text();
			end
			if (result_valid && result_ready) begin
				if (due_reports.size() == 0) begin
					n_err++;
					$display("%t unexpected report: found %0d, index %0d, overflow %0d",
						$time, found, match_index, count_overflow);
				end else begin
					want = due_reports.pop_front();
					n_checked++;
					if (want.found)
						n_found++;
					check_field("found", INDEX_W'(want.found), INDEX_W'(found));
					check_field("match_index", want.index, match_index);
					check_field("count_overflow", INDEX_W'(want.overflow),
						INDEX_W'(count_overflow));
				end
			end
		end
		errors          <= n_err;
		waiting         <= due_reports.size();
		reports_checked <= n_checked;
		reports_found   <= n_found;
	end

endmodule

// File: bench/testbench.sv
// testbench: drives configuration writes and text streams into first_match_substring_search
// and gives the verdict. Depends on fmss_pkg, fmss_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
	import fmss_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
	localparam int RANDOM_ITEMS   = 400;
	localparam int MIN_TEXTS      = 40;
	localparam int HOLD_CYCLES    = 150;
	localparam int RESULT_LATENCY = 4;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 text_valid   = 1'b0;
	logic                 text_ready;
	logic [7:0]           text_byte    = 8'h00;
	logic                 byte_present = 1'b0;
	logic                 end_of_text  = 1'b0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic                 found;
	logic [INDEX_W-1:0]   match_index;
	logic                 count_overflow;

	int errors;
	int waiting;
	int reports_checked;
	int reports_found;

	int send_gap_pct = 0;
	int stall_pct    = 0;
	int hold_req     = 0;
	int hold_ack     = 0;
	int hold_left    = 0;

	logic [7:0] pat [MAX_PATTERN];
	int         pat_len_raw = 0;
	int         alpha_base  = 97;
	int         alpha_size  = 3;
	int         items       = 0;
	int         texts       = 0;
	int         bytes_sent  = 0;
	int         settings    = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	first_match_substring_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_valid     (text_valid),
		.text_ready     (text_ready),
		.text_byte      (text_byte),
		.byte_present   (byte_present),
		.end_of_text    (end_of_text),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.found          (found),
		.match_index    (match_index),
		.count_overflow (count_overflow)
	);

	fmss_checker search_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.text_valid      (text_valid),
		.text_ready      (text_ready),
		.text_byte       (text_byte),
		.byte_present    (byte_present),
		.end_of_text     (end_of_text),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.found           (found),
		.match_index     (match_index),
		.count_overflow  (count_overflow),
		.errors          (errors),
		.waiting         (waiting),
		.reports_checked (reports_checked),
		.reports_found   (reports_found)
	);

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack     <= hold_req;
			hold_left    <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic p, input logic e);
		while ($urandom_range(99) < send_gap_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid   <= 1'b1;
		text_byte    <= b;
		byte_present <= p;
		end_of_text  <= e;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		if (p || e)
			items++;
		if (p && b != END_BYTE)
			bytes_sent++;
	endtask

	// quiesce: no reports outstanding and the pipeline empty
	task automatic drain();
		text_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_pattern(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high,
			input logic [CFG_W-1:0] len_word);
		int k;
		write_reg(REG_PAT_LOW, low);
		write_reg(REG_PAT_HIGH, high);
		write_reg(REG_PAT_LEN, len_word);
		cfg_valid <= 1'b0;
		for (k = 0; k < 8; k++) begin
			pat[k]   = low[8*k +: 8];
			pat[k+8] = high[8*k +: 8];
		end
		pat_len_raw = int'(len_word[CFG_LEN_W-1:0]);
		settings++;
	endtask

	function automatic int pat_len_used();
		return (pat_len_raw > MAX_PATTERN) ? MAX_PATTERN : pat_len_raw;
	endfunction

	function automatic logic [7:0] text_char();
		if ($urandom_range(4) != 0)
			return 8'(alpha_base + $urandom_range(alpha_size - 1));
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic random_pattern();
		logic [CFG_W-1:0] low;
		logic [CFG_W-1:0] high;
		logic [CFG_W-1:0] len_word;
		logic [7:0]       b;
		int               n;
		int               k;
		int               sel;
		int               wide;
		alpha_base = $urandom_range(252, 1);
		alpha_size = $urandom_range(3, 2);
		sel = $urandom_range(99);
		if (sel < 5)
			n = 0;
		else if (sel < 10)
			n = $urandom_range(31, 17);
		else if (sel < 15)
			n = MAX_PATTERN;
		else if (sel < 30)
			n = $urandom_range(15, 7);
		else
			n = $urandom_range(6, 1);
		low  = {$urandom, $urandom};
		high = {$urandom, $urandom};
		wide = ($urandom_range(9) == 0);
		for (k = 0; k < MAX_PATTERN && k < n; k++) begin
			b = wide ? 8'($urandom_range(255, 1)) : 8'(alpha_base + $urandom_range(alpha_size - 1));
			if (k < 8)
				low[8*k +: 8] = b;
			else
				high[8*(k-8) +: 8] = b;
		end
		// a zero byte in the pattern can never match
		if (n > 0 && $urandom_range(19) == 0) begin
			k = $urandom_range(((n > MAX_PATTERN) ? MAX_PATTERN : n) - 1);
			if (k < 8)
				low[8*k +: 8] = END_BYTE;
			else
				high[8*(k-8) +: 8] = END_BYTE;
		end
		len_word = ($urandom_range(9) == 0) ? {$urandom, $urandom} : '0;
		len_word[CFG_LEN_W-1:0] = CFG_LEN_W'(n);
		load_pattern(low, high, len_word);
	endtask

	task automatic random_text();
		logic [7:0] b;
		int         n;
		int         m;
		int         pos;
		int         k;
		int         sel;
		m = pat_len_used();
		n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
		for (pos = 0; pos < n; pos++) begin
			if ($urandom_range(99) < 8)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			if (m > 0 && pos + m <= n && $urandom_range(9) < 3) begin
				for (k = 0; k < m; k++) begin
					b = pat[k];
					if (b == END_BYTE)
						b = text_char();
					send_item(b, 1'b1, 1'b0);
				end
				pos += m - 1;
			end else begin
				send_item(text_char(), 1'b1, 1'b0);
			end
		end
		sel = $urandom_range(99);
		if (sel < 40)
			send_item(text_char(), 1'b1, 1'b1);
		else if (sel < 75)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		else if (sel < 95)
			send_item(END_BYTE, 1'b1, 1'b0);
		else
			send_item(END_BYTE, 1'b1, 1'b1);
		texts++;
	endtask

	initial begin
		int k;
		int item_base;
		int text_base;
		int phase;
		logic held;
		for (k = 0; k < MAX_PATTERN; k++)
			pat[k] = 8'h00;
		held = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern, empty text, then a one-byte text closed by a zero byte
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(END_BYTE, 1'b1, 1'b0);
		texts += 2;
		drain();

		// full-length pattern of all ones, closed by a byte carrying the end mark
		load_pattern('1, '1, 64'd16);
		send_item(8'h01, 1'b1, 1'b0);
		for (k = 0; k < 15; k++)
			send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		texts++;
		drain();

		// length field with junk above bit 4; an ignored transfer mid-text
		load_pattern(64'h4241, 64'h0, 64'hFFFF_FFFF_FFFF_FFE2);
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'h37, 1'b0, 1'b0);
		send_item(8'h42, 1'b1, 1'b0);
		send_item(END_BYTE, 1'b1, 1'b1);
		texts++;
		drain();

		// zero byte in the pattern
		load_pattern({$urandom, $urandom} & ~64'hFF, {$urandom, $urandom}, 64'd1);
		send_item(8'h78, 1'b1, 1'b1);
		texts++;
		drain();

		// unused register index, then a pattern change part way through a text
		write_reg(REG_SPARE, {$urandom, $urandom});
		load_pattern(64'h41, 64'h0, 64'd1);
		send_item(8'h42, 1'b1, 1'b0);
		drain();
		write_reg(REG_PAT_LOW, 64'h42);
		cfg_valid <= 1'b0;
		send_item(8'h42, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		texts++;
		drain();
		random_pattern();

		item_base = items;
		text_base = texts;
		while (items - item_base < RANDOM_ITEMS || texts - text_base < MIN_TEXTS) begin
			phase = (texts / 3) % 4;
			case (phase)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 63; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 63; end
				default: begin send_gap_pct = 16; stall_pct = 16; end
			endcase
			if (!held && texts - text_base >= 20) begin
				// receiver holds off while short texts keep coming: fills the report queue
				held = 1'b1;
				drain();
				send_gap_pct = 0;
				hold_req++;
				for (k = 0; k < 12; k++) begin
					send_item(text_char(), 1'b1, 1'b1);
					texts++;
				end
			end
			if ($urandom_range(3) == 0) begin
				drain();
				random_pattern();
			end
			random_text();
		end

		text_valid <= 1'b0;
		send_gap_pct = 0;
		stall_pct    = 0;
		@(posedge clk);
		for (k = 0; k < 10000 && waiting != 0; k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (waiting != 0)
			$display("%t %0d search reports never arrived", $time, waiting);
		$display("ran %0d texts (%0d bytes, %0d transfers) over %0d pattern settings,",
			texts, bytes_sent, items, settings);
		$display("four idling phases and one long receiver hold; %0d reports, %0d found",
			reports_checked, reports_found);
		if (errors == 0 && waiting == 0)
			$display("first_match_substring_search: match");
		else
			$display("first_match_substring_search: mismatch");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("first_match_substring_search: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
design/fmss_pkg.sv
design/fmss_front.sv
design/fmss_queue.sv
design/fmss_back.sv
design/first_match_substring_search.sv
bench/fmss_checker.sv
bench/testbench.sv
